### rtl/sprc_pkg.sv
// Shared constants and types for the frame receiver with checksum.
`timescale 1ns / 1ps
`default_nettype none
package sprc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned SUM_W   = 13;
    localparam int unsigned ID_W    = 11;
    localparam int unsigned ID_LO_W = 3;
    localparam int unsigned PAY_N   = 8;
    localparam int unsigned PAY_IDX_W = 3;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'hF0;
    localparam logic [BYTE_W-1:0] SECOND_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] CHAN_A      = 8'hAA;
    localparam logic [BYTE_W-1:0] CHAN_B      = 8'hBB;

    // Frame positions
    localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 5'd1;
    localparam logic [POS_W-1:0] POS_CHAN   = 5'd2;
    localparam logic [POS_W-1:0] POS_BODY   = 5'd3;
    localparam logic [POS_W-1:0] POS_ID_HI  = 5'd4;
    localparam logic [POS_W-1:0] POS_ID_LO  = 5'd5;
    localparam logic [POS_W-1:0] POS_DATA   = 5'd9;
    localparam logic [POS_W-1:0] POS_CHECK  = 5'd17;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte             channel;
        logic [ID_W-1:0]   message_id;
        t_byte             data_b0;
        t_byte             data_b1;
        t_byte             data_b2;
        t_byte             data_b3;
        t_byte             data_b4;
        t_byte             data_b5;
        t_byte             data_b6;
        t_byte             data_b7;
        logic              frame_status;
    } t_result;

endpackage
`default_nettype wire

### rtl/sprc_if.sv
// Channel interfaces: received byte requests in, frame result requests out.
`timescale 1ns / 1ps
`default_nettype none
interface sprc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sprc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  channel;
    logic [10:0] message_id;
    logic [7:0]  data_b0;
    logic [7:0]  data_b1;
    logic [7:0]  data_b2;
    logic [7:0]  data_b3;
    logic [7:0]  data_b4;
    logic [7:0]  data_b5;
    logic [7:0]  data_b6;
    logic [7:0]  data_b7;
    logic        frame_status;

    modport source (output valid, output channel, output message_id,
                    output data_b0, output data_b1, output data_b2, output data_b3,
                    output data_b4, output data_b5, output data_b6, output data_b7,
                    output frame_status, input ready);
    modport sink   (input valid, input channel, input message_id,
                    input data_b0, input data_b1, input data_b2, input data_b3,
                    input data_b4, input data_b5, input data_b6, input data_b7,
                    input frame_status, output ready);
endinterface
`default_nettype wire

### rtl/sprc_csum.sv
// Checksum fold: two end-around-carry folds of the running sum, then 8-bit negate.
`timescale 1ns / 1ps
`default_nettype none
module sprc_csum (
    input  wire logic [sprc_pkg::SUM_W-1:0]  i_sum,
    output logic      [sprc_pkg::BYTE_W-1:0] o_expect
);
    import sprc_pkg::*;

    logic [BYTE_W:0] w_fold1;
    logic [BYTE_W:0] w_fold2;

    always_comb begin
        w_fold1  = {1'b0, i_sum[BYTE_W-1:0]} + {4'b0, i_sum[SUM_W-1:BYTE_W]};
        w_fold2  = {1'b0, w_fold1[BYTE_W-1:0]} + {{BYTE_W{1'b0}}, w_fold1[BYTE_W]};
        o_expect = BYTE_W'(~w_fold2[BYTE_W-1:0] + 8'd1);
    end

endmodule
`default_nettype wire

### rtl/sprc_framer.sv
// Frame hunt, running sum and field capture; emits one result at the check byte.
`timescale 1ns / 1ps
`default_nettype none
module sprc_framer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire sprc_pkg::t_byte       i_byte,
    output logic                       o_fire,
    output sprc_pkg::t_result          o_result
);
    import sprc_pkg::*;

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [SUM_W-1:0]   r_sum,   n_sum;
    t_byte              r_chan;
    t_byte              r_id_hi;
    logic [ID_LO_W-1:0] r_id_lo;
    t_byte              r_pay [PAY_N];

    logic [POS_W-1:0]   w_pay_idx;
    logic [SUM_W-1:0]   w_sum_add;
    logic [POS_W-1:0]   w_hunt_pos;
    logic [SUM_W-1:0]   w_hunt_sum;
    t_byte              w_expect;

    sprc_csum u_csum (
        .i_sum    (r_sum),
        .o_expect (w_expect)
    );

    assign w_pay_idx  = r_pos - POS_DATA;
    assign w_sum_add  = r_sum + {5'b0, i_byte};
    assign w_hunt_pos = (i_byte == START_BYTE) ? POS_SECOND : POS_HUNT;
    assign w_hunt_sum = (i_byte == START_BYTE) ? {5'b0, i_byte} : '0;

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        o_fire = 1'b0;
        if (r_pos == POS_HUNT) begin
            n_pos = w_hunt_pos;
            n_sum = w_hunt_sum;
        end else if (r_pos == POS_SECOND) begin
            n_pos = (i_byte == SECOND_BYTE) ? POS_CHAN  : w_hunt_pos;
            n_sum = (i_byte == SECOND_BYTE) ? w_sum_add : w_hunt_sum;
        end else if (r_pos == POS_CHAN) begin
            n_pos = (i_byte == CHAN_A || i_byte == CHAN_B) ? POS_BODY  : w_hunt_pos;
            n_sum = (i_byte == CHAN_A || i_byte == CHAN_B) ? w_sum_add : w_hunt_sum;
        end else if (r_pos < POS_CHECK) begin
            n_pos = r_pos + 5'd1;
            n_sum = w_sum_add;
        end else begin
            n_pos  = POS_HUNT;
            n_sum  = '0;
            o_fire = i_accept;
        end
    end

    always_comb begin
        o_result.channel      = r_chan;
        o_result.message_id   = {r_id_hi, r_id_lo};
        o_result.data_b0      = r_pay[0];
        o_result.data_b1      = r_pay[1];
        o_result.data_b2      = r_pay[2];
        o_result.data_b3      = r_pay[3];
        o_result.data_b4      = r_pay[4];
        o_result.data_b5      = r_pay[5];
        o_result.data_b6      = r_pay[6];
        o_result.data_b7      = r_pay[7];
        o_result.frame_status = (i_byte == w_expect) ? STATUS_OK : STATUS_MISMATCH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_HUNT;
            r_sum   <= '0;
            r_chan  <= '0;
            r_id_hi <= '0;
            r_id_lo <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (r_pos == POS_CHAN && (i_byte == CHAN_A || i_byte == CHAN_B)) begin
                r_chan <= i_byte;
            end
            if (r_pos == POS_ID_HI) begin
                r_id_hi <= i_byte;
            end
            if (r_pos == POS_ID_LO) begin
                r_id_lo <= i_byte[BYTE_W-1 -: ID_LO_W];
            end
        end
    end

    // payload bytes 9..16, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos >= POS_DATA && r_pos < POS_CHECK) begin
            r_pay[w_pay_idx[PAY_IDX_W-1:0]] <= i_byte;
        end
    end

endmodule
`default_nettype wire

### rtl/sprc_out_stage.sv
// Result output register; frees itself for a new result in the cycle it is taken.
`timescale 1ns / 1ps
`default_nettype none
module sprc_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire sprc_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_space,
    output sprc_pkg::t_result      o_result
);
    import sprc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

### rtl/sync_packet_receiver_checksum.sv
// Top level: 18-byte frame receiver with end-around-carry checksum check.
//
//  channel | dir | modport | payload
//  --------+-----+---------+--------------------------------------------------
//  i_rx    | in  | sink    | rx_byte[7:0]
//  o_res   | out | source  | channel, message_id[10:0], data_b0..b7, frame_status
//
// Unless stalled, one byte is taken per cycle; every byte is finished in the
// cycle it is accepted (compare, 13-bit add, capture): one byte per clock.
// The closing byte's request loads the result register; i_rx.ready drops only
// while that register holds a result the sink has not taken.
// Synchronous active-low reset returns the hunt to the start byte and empties
// the result register. Payload bytes are never reset.
`timescale 1ns / 1ps
`default_nettype none
module sync_packet_receiver_checksum (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sprc_rx_if.sink    i_rx,
    sprc_res_if.source o_res
);
    import sprc_pkg::*;

    logic    w_accept;
    logic    w_fire;
    logic    w_space;
    t_result w_frame_res;
    t_result w_out_res;

    // Byte accepted whenever the result register has room (or is being drained).
    assign i_rx.ready = w_space;
    assign w_accept   = i_rx.valid && w_space;

    sprc_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx.rx_byte),
        .o_fire   (w_fire),
        .o_result (w_frame_res)
    );

    sprc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_frame_res),
        .i_ready  (o_res.ready),
        .o_valid  (o_res.valid),
        .o_space  (w_space),
        .o_result (w_out_res)
    );

    // Fan the result struct out onto the channel fields.
    assign o_res.channel      = w_out_res.channel;
    assign o_res.message_id   = w_out_res.message_id;
    assign o_res.data_b0      = w_out_res.data_b0;
    assign o_res.data_b1      = w_out_res.data_b1;
    assign o_res.data_b2      = w_out_res.data_b2;
    assign o_res.data_b3      = w_out_res.data_b3;
    assign o_res.data_b4      = w_out_res.data_b4;
    assign o_res.data_b5      = w_out_res.data_b5;
    assign o_res.data_b6      = w_out_res.data_b6;
    assign o_res.data_b7      = w_out_res.data_b7;
    assign o_res.frame_status = w_out_res.frame_status;

endmodule
`default_nettype wire

### rtl/sprc_checker.sv
// Port-level checks on the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sprc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_channel,
    input wire logic [10:0] i_message_id,
    input wire logic        i_frame_status
);
    import sprc_pkg::*;

    // Empty result register never stalls the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // Every result carries a valid channel byte.
    a_channel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_channel == CHAN_A || i_channel == CHAN_B))
        else $error("result with bad channel byte");

    // A result that shows after an idle or a taken one came from a byte request.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |=> (!i_out_valid || $past(i_in_valid && i_in_ready)))
        else $error("result without an accepted byte");

    // Stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_channel) && $stable(i_message_id)
             && $stable(i_frame_status)))
        else $error("stalled result changed");

endmodule

bind sync_packet_receiver_checksum sprc_checker u_sprc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_rx.valid),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_channel      (o_res.channel),
    .i_message_id   (o_res.message_id),
    .i_frame_status (o_res.frame_status)
);
`default_nettype wire

### bench/sprc_frame_checker.sv
// Scoreboard: predicts frame results from accepted byte requests and checks the result channel.
`timescale 1ns / 1ps
module sprc_frame_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sprc_rx_if        i_rx,
    sprc_res_if       i_res,
    output int        o_err_count,
    output int        o_pending,
    output int        o_frames,
    output int        o_bad_sums
);
    import sprc_pkg::*;

    // shadow of the receiver state
    logic [POS_W-1:0]   frame_pos;
    logic [SUM_W-1:0]   byte_sum;
    t_byte              chan_q;
    t_byte              id_hi_q;
    logic [ID_LO_W-1:0] id_lo_q;
    t_byte              payload_q [PAY_N];

    t_result expected_frames [$];
    int      err_count = 0;
    int      frames    = 0;
    int      bad_sums  = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t sprc_frame_checker: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // end-around carry twice, then two's complement in 8 bits
    function automatic t_byte fold_sum(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        v = SUM_W'(s[BYTE_W-1:0]) + (s >> BYTE_W);
        v = SUM_W'(v[BYTE_W-1:0]) + (v >> BYTE_W);
        return 8'd0 - v[BYTE_W-1:0];
    endfunction

    // a failed header byte may itself open a new frame
    task automatic restart_hunt(input t_byte b);
        if (b == START_BYTE) begin
            byte_sum  = SUM_W'(b);
            frame_pos = POS_SECOND;
        end else begin
            byte_sum  = '0;
            frame_pos = POS_HUNT;
        end
    endtask

    task automatic absorb_byte(input t_byte b);
        t_result r;
        if (frame_pos == POS_HUNT) begin
            restart_hunt(b);
        end else if (frame_pos == POS_SECOND) begin
            if (b == SECOND_BYTE) begin
                byte_sum  = byte_sum + SUM_W'(b);
                frame_pos = POS_CHAN;
            end else begin
                restart_hunt(b);
            end
        end else if (frame_pos == POS_CHAN) begin
            if (b == CHAN_A || b == CHAN_B) begin
                byte_sum  = byte_sum + SUM_W'(b);
                chan_q    = b;
                frame_pos = POS_BODY;
            end else begin
                restart_hunt(b);
            end
        end else if (frame_pos < POS_CHECK) begin
            byte_sum = byte_sum + SUM_W'(b);
            if (frame_pos == POS_ID_HI)
                id_hi_q = b;
            else if (frame_pos == POS_ID_LO)
                id_lo_q = b[7:5];
            else if (frame_pos >= POS_DATA)
                payload_q[PAY_IDX_W'(frame_pos - POS_DATA)] = b;
            frame_pos = frame_pos + 1'b1;
        end else begin
            r.channel      = chan_q;
            r.message_id   = {id_hi_q, id_lo_q};
            r.data_b0      = payload_q[0];
            r.data_b1      = payload_q[1];
            r.data_b2      = payload_q[2];
            r.data_b3      = payload_q[3];
            r.data_b4      = payload_q[4];
            r.data_b5      = payload_q[5];
            r.data_b6      = payload_q[6];
            r.data_b7      = payload_q[7];
            r.frame_status = (b == fold_sum(byte_sum)) ? STATUS_OK : STATUS_MISMATCH;
            expected_frames.push_back(r);
            frame_pos = POS_HUNT;
            byte_sum  = '0;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("result with no frame pending: ch %h id %h",
                                      i_res.channel, i_res.message_id));
        end else begin
            want = expected_frames.pop_front();
            check_field("channel",      i_res.channel,      want.channel);
            check_field("message_id",   i_res.message_id,   want.message_id);
            check_field("data_b0",      i_res.data_b0,      want.data_b0);
            check_field("data_b1",      i_res.data_b1,      want.data_b1);
            check_field("data_b2",      i_res.data_b2,      want.data_b2);
            check_field("data_b3",      i_res.data_b3,      want.data_b3);
            check_field("data_b4",      i_res.data_b4,      want.data_b4);
            check_field("data_b5",      i_res.data_b5,      want.data_b5);
            check_field("data_b6",      i_res.data_b6,      want.data_b6);
            check_field("data_b7",      i_res.data_b7,      want.data_b7);
            check_field("frame_status", i_res.frame_status, want.frame_status);
            frames++;
            if (want.frame_status == STATUS_MISMATCH)
                bad_sums++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = POS_HUNT;
            byte_sum  = '0;
            chan_q    = '0;
            id_hi_q   = '0;
            id_lo_q   = '0;
            foreach (payload_q[i])
                payload_q[i] = '0;
            expected_frames.delete();
        end else begin
            // predict first so ordering holds even for a same-edge result
            if (i_rx.valid && i_rx.ready)
                absorb_byte(i_rx.rx_byte);
            if (i_res.valid && i_res.ready)
                check_result();
        end
        o_err_count <= err_count;
        o_pending   <= expected_frames.size();
        o_frames    <= frames;
        o_bad_sums  <= bad_sums;
    end

endmodule

### bench/sync_packet_receiver_checksum_tb.sv
// Testbench top: byte stimulus, result-side back-pressure and verdict for the frame receiver.
`timescale 1ns / 1ps
module sync_packet_receiver_checksum_tb;
    import sprc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;    // long result-side stall, forces input back-pressure
    localparam int PHASE_BYTES  = 290;    // random byte requests per random-traffic phase
    localparam int DRAIN_CYCLES = 20;     // quiet time after the last result
    localparam int FRAME_LEN    = 18;
    localparam int BODY_LEN     = 14;     // frame bytes 3..16

    logic clk;
    logic rst_n;

    sprc_rx_if  rx_ch ();
    sprc_res_if res_ch ();

    int err_count;
    int pending;
    int frames_done;
    int bad_sums;

    int send_idle_pct = 0;  // chance the sender stays idle ahead of a request
    int recv_idle_pct = 0;  // chance the result sink drops ready in a cycle
    int hold_ask      = 0;  // bumped by stimulus to ask for one long result stall
    int bytes_sent    = 0;
    int cycles        = 0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    sync_packet_receiver_checksum i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    sprc_frame_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_rx        (rx_ch),
        .i_res       (res_ch),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_frames    (frames_done),
        .o_bad_sums  (bad_sums)
    );

    // Watchdog: a hung handshake or lost result ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("sync_packet_receiver_checksum_tb: done, errors");
            $finish;
        end
    end

    // Result sink. The long hold is counted here so the sender keeps pushing
    // requests meanwhile; the block's single result register fills and it
    // must stall its input until the hold ends.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Checksum byte that makes a frame good: sum bytes 0..16, fold the
    // carries back in twice, negate.
    function automatic t_byte good_check_byte(input t_byte f [FRAME_LEN]);
        int s;
        s = 0;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            s += f[i];
        s = (s & 255) + (s >> 8);
        s = (s & 255) + (s >> 8);
        return t_byte'(-s);
    endfunction

    // Skewed toward the extremes and the start byte, which also exercises
    // a start byte showing up inside a frame body.
    function automatic t_byte rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return START_BYTE;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // One request on the byte channel. Idle cycles carry junk on the data
    // lines so a byte taken without valid would show up as a mismatch.
    task automatic send_byte(input t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= t_byte'($urandom);
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_byte chan, input t_byte body [BODY_LEN],
                              input bit corrupt);
        t_byte f [FRAME_LEN];
        f[0] = START_BYTE;
        f[1] = SECOND_BYTE;
        f[2] = chan;
        for (int i = 0; i < BODY_LEN; i++)
            f[3 + i] = body[i];
        f[FRAME_LEN-1] = good_check_byte(f);
        if (corrupt)
            f[FRAME_LEN-1] ^= t_byte'($urandom_range(255, 1));
        foreach (f[i])
            send_byte(f[i]);
    endtask

    task automatic send_random_frame();
        t_byte body [BODY_LEN];
        foreach (body[i])
            body[i] = rand_byte();
        send_frame($urandom_range(1) ? CHAN_A : CHAN_B, body, $urandom_range(99) < 30);
    endtask

    // Header that breaks off: bad second byte, bad channel byte, or loose noise.
    task automatic send_broken();
        t_byte bad;
        int    n;
        bad = t_byte'($urandom);
        case ($urandom_range(2))
            0: begin
                if (bad == SECOND_BYTE)
                    bad = START_BYTE;
                send_byte(START_BYTE);
                send_byte(bad);
            end
            1: begin
                if (bad == CHAN_A || bad == CHAN_B)
                    bad = START_BYTE;
                send_byte(START_BYTE);
                send_byte(SECOND_BYTE);
                send_byte(bad);
            end
            default: begin
                n = $urandom_range(4, 1);
                repeat (n)
                    send_byte(rand_byte());
            end
        endcase
    endtask

    task automatic random_traffic(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 80)
                send_random_frame();
            else
                send_broken();
        end
    endtask

    // Sender goes quiet until every predicted result has been taken.
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        t_byte body [BODY_LEN];

        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: junk while hunting, a start byte rejected as second byte
        // and reused as start, a start byte rejected as channel and reused,
        // then a frame on channel B with the id at its maximum and payload
        // bytes at both extremes.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(SECOND_BYTE);
        body = '{8'h00, 8'hFF, 8'hE0, 8'h1F, 8'h00, 8'hFF,
                 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80};
        // the channel slot gets a start byte first, then the real frame follows
        send_byte(START_BYTE);
        send_byte(SECOND_BYTE);
        send_byte(START_BYTE);
        send_frame(CHAN_B, body, 1'b0);
        wait_drained();

        // Sender mostly busy, sink stalls about two thirds of the time.
        send_idle_pct = 6;
        recv_idle_pct = 67;
        random_traffic(PHASE_BYTES);
        wait_drained();

        // Long sink hold with back-to-back frames: input must back up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ask++;
        repeat (4)
            send_random_frame();
        wait_drained();

        // Sender gappy, sink nearly always ready.
        send_idle_pct = 67;
        recv_idle_pct = 6;
        random_traffic(PHASE_BYTES);
        wait_drained();

        // Full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(PHASE_BYTES);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d byte requests, %0d frames checked (%0d with bad checksum)",
                 bytes_sent, frames_done, bad_sums);
        $display("summary: header restarts, junk bytes, both channels, long result stall");
        if (err_count == 0 && pending == 0)
            $display("sync_packet_receiver_checksum_tb: done, clean");
        else
            $display("sync_packet_receiver_checksum_tb: done, errors");
        $finish;
    end

endmodule
